// File: rtl/lifegen_pkg.sv
// Shared types, constants and the Life rule for the generation stencil.
package lifegen_pkg;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS = 2'd1;
   localparam int CSR_COLS_W     = 6;
   localparam int CSR_ROWS_W     = 11;
   localparam int CSR_COLS_RESET = 24;
   localparam int CSR_ROWS_RESET = 13;

   // Result field widths.
   localparam int OUT_COL_W = 5;
   localparam int OUT_ROW_W = 10;

   // B3/S23 neighbour counts.
   localparam int LIFE_BIRTH   = 3;
   localparam int LIFE_SURVIVE = 2;

   // Result slots of one item, in emission order.
   localparam logic [1:0] SLOT_UP_LEFT = 2'd0;
   localparam logic [1:0] SLOT_UP      = 2'd1;
   localparam logic [1:0] SLOT_LEFT    = 2'd2;
   localparam logic [1:0] SLOT_HERE    = 2'd3;

   // Results of one item handed to the emitter: which slots exist and their states.
   typedef struct packed {
      logic [3:0] mask;
      logic [3:0] next;
   } emit_load_type;

   // Window bit k*3+j holds column k (0 oldest) and row j (0 top).
   // lower selects the center cell in row 2, whose lower row lies outside the window.
   function automatic logic life_next(input logic [8:0] w, input logic lower);
      logic [8:0] nbr_mask;
      logic [3:0] n;
      logic       center;
      nbr_mask = lower ? 9'b110_010_110 : 9'b111_101_111;
      center   = lower ? w[5] : w[4];
      n        = '0;
      for (int i = 0; i < 9; i++) begin
         n = n + 4'(w[i] & nbr_mask[i]);
      end
      return (n == 4'(LIFE_BIRTH)) || (center && (n == 4'(LIFE_SURVIVE)));
   endfunction

endpackage

// File: rtl/lifegen_emit.sv
// Result sequencer: sends the up to four results of one item through an output register.
module lifegen_emit #(
   parameter int COL_W = 5,
   parameter int ROW_W = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_valid,
   input  lifegen_pkg::emit_load_type load,
   input  logic [COL_W-1:0]          load_col,
   input  logic [ROW_W-1:0]          load_row,
   output logic                      load_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_next_alive,
   output logic [lifegen_pkg::OUT_COL_W-1:0] rsp_out_col,
   output logic [lifegen_pkg::OUT_ROW_W-1:0] rsp_out_row,
   output logic                      rsp_frame_last
);
   import lifegen_pkg::*;

   logic [3:0]       pend_ff, pend_in;
   logic [3:0]       next_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             out_valid_ff, out_valid_in;
   logic             out_alive_ff;
   logic [OUT_COL_W-1:0] out_col_ff;
   logic [OUT_ROW_W-1:0] out_row_ff;
   logic             out_last_ff;
   logic             out_free;
   logic             emit;
   logic [1:0]       sel;
   logic [3:0]       sel_bit;
   logic [COL_W-1:0] sel_col;
   logic [ROW_W-1:0] sel_row;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit     = (pend_ff != 4'b0) && out_free;

   // Lowest pending slot goes first.
   always_comb begin
      if (pend_ff[0]) begin
         sel = SLOT_UP_LEFT;
      end else if (pend_ff[1]) begin
         sel = SLOT_UP;
      end else if (pend_ff[2]) begin
         sel = SLOT_LEFT;
      end else begin
         sel = SLOT_HERE;
      end
   end

   assign sel_bit = 4'b0001 << sel;

   always_comb begin
      unique case (sel)
         SLOT_UP_LEFT: begin
            sel_col = col_ff - 1'b1;
            sel_row = row_ff - 1'b1;
         end
         SLOT_UP: begin
            sel_col = col_ff;
            sel_row = row_ff - 1'b1;
         end
         SLOT_LEFT: begin
            sel_col = col_ff - 1'b1;
            sel_row = row_ff;
         end
         default: begin
            sel_col = col_ff;
            sel_row = row_ff;
         end
      endcase
   end

   // A new item may load when nothing is pending or the current one is about to send its last result.
   assign load_ready = (pend_ff == 4'b0) || (emit && (pend_ff == sel_bit));

   always_comb begin
      pend_in = pend_ff;
      if (emit) begin
         pend_in = pend_ff & ~sel_bit;
      end
      if (load_valid && load_ready) begin
         pend_in = load.mask;
      end
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         next_ff <= load.next;
         col_ff  <= load_col;
         row_ff  <= load_row;
      end
      if (emit) begin
         out_alive_ff <= next_ff[sel];
         out_col_ff   <= OUT_COL_W'(sel_col);
         out_row_ff   <= OUT_ROW_W'(sel_row);
         out_last_ff  <= (sel == SLOT_HERE);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_next_alive = out_alive_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

// File: rtl/life_generation_stencil.sv
// Streaming Life (B3/S23) generation over a bounded grid, with line memory and window.
//
// Cells of the current generation enter on the req_ channel, one item per cell, in
// raster order. The next state of each cell leaves on the rsp_ channel with its
// column and row; rsp_frame_last marks the final cell of the grid. A cell's result
// is sent once its lower-right neighbour has arrived or lies outside the grid, so
// results trail the input by about one row.
// One item is accepted per cycle while req_stall is low. An item with two or more
// results (the end of a row, the cells of the last row) holds req_stall for its extra
// results; the emitter hands out one result per cycle while rsp_stall is low.
// On acceptance the line memory is read and the item enters the window stage; the
// window and rule results then load the emitter, which moves each result into the
// output register.
// The output register lets the block keep taking items while a result waits on
// rsp_stall; when it cannot drain, req_stall rises.
// The csr_ port sets cols (index 0) and rows (index 1). Any write of those restarts
// the frame at the top-left cell. Reset sets 24 columns by 13 rows and restarts the
// frame; the line memory needs no clearing, since rows above the grid count as dead.
module life_generation_stencil #(
   parameter int MAX_COLS = 32,
   parameter int MAX_ROWS = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_cell_alive,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_next_alive,
   output logic [lifegen_pkg::OUT_COL_W-1:0] rsp_out_col,
   output logic [lifegen_pkg::OUT_ROW_W-1:0] rsp_out_row,
   output logic rsp_frame_last,
   input  logic csr_wr_en,
   input  logic [lifegen_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lifegen_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lifegen_pkg::*;

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int LAST_COL_RESET = ((CSR_COLS_RESET > MAX_COLS) ? MAX_COLS : CSR_COLS_RESET) - 1;
   localparam int LAST_ROW_RESET = ((CSR_ROWS_RESET > MAX_ROWS) ? MAX_ROWS : CSR_ROWS_RESET) - 1;

   // Configuration, held as the index of the last column and row.
   logic [COL_W-1:0] last_col_ff, last_col_in;
   logic [ROW_W-1:0] last_row_ff, last_row_in;
   int               cfg_val;

   // Raster position of the next item.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             req_accept;
   logic             end_col;
   logic             last_row;

   // Item in the window stage.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_alive_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_end_ff;
   logic             s1_last_ff;
   logic             s1_ge1_ff;
   logic             s1_ge2_ff;
   logic             s1_adv;

   // Line memory: bit 1 is the row above, bit 0 the row two above.
   logic [1:0]       line_mem [MAX_COLS];
   logic [1:0]       rd_ff;
   logic [1:0]       fwd_data_ff;
   logic             fwd_hit_ff;
   logic [1:0]       entry;
   logic [1:0]       wr_data;

   logic [8:0]       window_ff, window_in;
   logic [2:0]       col_bits;
   logic [8:0]       window_shift;

   emit_load_type    load;
   logic             load_ready;

   // ---------------- configuration ----------------
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      cfg_val     = 0;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COLS: begin
               cfg_val = int'(csr_wdata[CSR_COLS_W-1:0]);
               if (cfg_val == 0) begin
                  last_col_in = '0;
               end else if (cfg_val > MAX_COLS) begin
                  last_col_in = COL_W'(MAX_COLS - 1);
               end else begin
                  last_col_in = COL_W'(cfg_val - 1);
               end
            end
            CSR_ROWS: begin
               cfg_val = int'(csr_wdata[CSR_ROWS_W-1:0]);
               if (cfg_val == 0) begin
                  last_row_in = '0;
               end else if (cfg_val > MAX_ROWS) begin
                  last_row_in = ROW_W'(MAX_ROWS - 1);
               end else begin
                  last_row_in = ROW_W'(cfg_val - 1);
               end
            end
            default: begin
               cfg_val = 0;
            end
         endcase
      end
   end

   // A write to a known register restarts the frame.
   logic cfg_restart;
   assign cfg_restart = csr_wr_en && ((csr_index == CSR_COLS) || (csr_index == CSR_ROWS));

   // ---------------- input side ----------------
   assign req_stall  = s1_valid_ff && !load_ready;
   assign req_accept = req_valid && !req_stall;
   assign s1_adv     = s1_valid_ff && load_ready;
   assign end_col    = (col_ff == last_col_ff);
   assign last_row   = (row_ff == last_row_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (end_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- window stage ----------------
   // An item can read its entry at the edge where the previous item's write lands, so that write is forwarded.
   assign entry   = fwd_hit_ff ? fwd_data_ff : rd_ff;
   assign wr_data = {s1_alive_ff, entry[1]};
   assign col_bits = {s1_alive_ff, entry[1] & s1_ge1_ff, entry[0] & s1_ge2_ff};
   assign window_in = (s1_col_ff == '0) ? {col_bits, 6'b0} : {col_bits, window_ff[8:3]};
   assign window_shift = {3'b0, window_in[8:3]};

   always_comb begin
      load.mask[SLOT_UP_LEFT] = s1_ge1_ff && (s1_col_ff != '0);
      load.mask[SLOT_UP]      = s1_ge1_ff && s1_end_ff;
      load.mask[SLOT_LEFT]    = s1_last_ff && (s1_col_ff != '0);
      load.mask[SLOT_HERE]    = s1_last_ff && s1_end_ff;
      load.next[SLOT_UP_LEFT] = life_next(window_in, 1'b0);
      load.next[SLOT_UP]      = life_next(window_shift, 1'b0);
      load.next[SLOT_LEFT]    = life_next(window_in, 1'b1);
      load.next[SLOT_HERE]    = life_next(window_shift, 1'b1);
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= COL_W'(LAST_COL_RESET);
         last_row_ff <= ROW_W'(LAST_ROW_RESET);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         window_ff   <= '0;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (cfg_restart) begin
            window_ff <= '0;
         end else if (s1_adv) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_alive_ff <= req_cell_alive;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_end_ff   <= end_col;
         s1_last_ff  <= last_row;
         s1_ge1_ff   <= (row_ff != '0);
         s1_ge2_ff   <= (row_ff > ROW_W'(1));
         fwd_hit_ff  <= s1_adv && (s1_col_ff == col_ff);
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_col_ff] <= wr_data;
      end
      if (req_accept) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   // ---------------- result side ----------------
   lifegen_emit #(
      .COL_W(COL_W),
      .ROW_W(ROW_W)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (s1_valid_ff),
      .load           (load),
      .load_col       (s1_col_ff),
      .load_row       (s1_row_ff),
      .load_ready     (load_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_alive (rsp_next_alive),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last)
   );

`ifndef NO_ASSERTIONS
   a_position_in_grid: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= last_col_ff) && (row_ff <= last_row_ff))
      else $error("raster position outside the configured grid");

   a_window_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff)
      else $error("window stage item lost while stalled");

   a_window_takes_cell: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !cfg_restart |=> window_ff[8] == $past(s1_alive_ff))
      else $error("window newest cell does not match the item");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming Life generation stencil.
module tb_top;
   import lifegen_pkg::*;

   localparam int MAX_COLS      = 32;
   localparam int MAX_ROWS      = 1024;
   localparam int CLOCK_HALF    = 6;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_CELLS  = 60;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic                 alive;
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      logic                 last;
   } cell_state_type;

   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic                   req_cell_alive = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic                   rsp_next_alive;
   logic [OUT_COL_W-1:0]   rsp_out_col;
   logic [OUT_ROW_W-1:0]   rsp_out_row;
   logic                   rsp_frame_last;
   logic                   csr_wr_en      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;

   life_generation_stencil #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cell_alive(req_cell_alive),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_next_alive(rsp_next_alive),
      .rsp_out_col(rsp_out_col),
      .rsp_out_row(rsp_out_row),
      .rsp_frame_last(rsp_frame_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Predictor state: geometry, the two previous rows, the window and the scan position.
   logic [CSR_COLS_W-1:0] cfg_cols = CSR_COLS_W'(CSR_COLS_RESET);
   logic [CSR_ROWS_W-1:0] cfg_rows = CSR_ROWS_W'(CSR_ROWS_RESET);
   bit                    row_above     [MAX_COLS];
   bit                    row_two_above [MAX_COLS];
   logic [8:0]            nbhd = '0;
   int unsigned           scan_col = 0;
   int unsigned           scan_row = 0;
   cell_state_type        pending_states[$];

   cell_state_type want_state;
   int unsigned cells_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches   = 0;
   int unsigned geometries   = 0;
   int unsigned holds_done   = 0;
   int unsigned cycle_count;
   bit          quiet        = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_active  = 1'b0;

   function automatic int unsigned grid_cols();
      if (cfg_cols == 0) return 1;
      return (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
   endfunction

   function automatic int unsigned grid_rows();
      if (cfg_rows == 0) return 1;
      return (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
   endfunction

   // The center cell sits in window column 1; rows below the window are dead.
   function automatic logic life_next_state(logic [8:0] w, int center_row);
      int count;
      count = 0;
      for (int k = 0; k < 3; k++) begin
         for (int j = center_row - 1; j <= center_row + 1; j++) begin
            if (j <= 2 && !(k == 1 && j == center_row)) count += w[k * 3 + j];
         end
      end
      return (count == LIFE_BIRTH) || (w[3 + center_row] && count == LIFE_SURVIVE);
   endfunction

   task automatic push_state(logic alive, int unsigned c, int unsigned r, logic last);
      cell_state_type s;
      s.alive = alive;
      s.col   = OUT_COL_W'(c);
      s.row   = OUT_ROW_W'(r);
      s.last  = last;
      pending_states.push_back(s);
   endtask

   task automatic predict_next_states(logic alive);
      int unsigned nc, nr, c, r;
      logic [2:0]  column;
      logic [8:0]  shifted;
      logic        end_col, last_row;
      nc = grid_cols();
      nr = grid_rows();
      c  = scan_col;
      r  = scan_row;
      if (c >= nc || r >= nr) begin
         c = 0;
         r = 0;
      end
      end_col  = (c == nc - 1);
      last_row = (r == nr - 1);
      column = {alive, (r >= 1) ? row_above[c] : 1'b0, (r >= 2) ? row_two_above[c] : 1'b0};
      if (c == 0) nbhd = {column, 6'b0};
      else nbhd = {column, nbhd[8:3]};
      row_two_above[c] = row_above[c];
      row_above[c]     = alive;
      shifted = {3'b000, nbhd[8:3]};
      if (r >= 1 && c >= 1) push_state(life_next_state(nbhd, 1), c - 1, r - 1, 1'b0);
      if (r >= 1 && end_col) push_state(life_next_state(shifted, 1), c, r - 1, 1'b0);
      if (last_row && c >= 1) push_state(life_next_state(nbhd, 2), c - 1, r, 1'b0);
      if (last_row && end_col) push_state(life_next_state(shifted, 2), c, r, 1'b1);
      if (end_col) begin
         scan_col = 0;
         scan_row = last_row ? 0 : r + 1;
      end else begin
         scan_col = c + 1;
         scan_row = r;
      end
   endtask

   task automatic apply_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_COLS: cfg_cols = data[CSR_COLS_W-1:0];
         CSR_ROWS: cfg_rows = data[CSR_ROWS_W-1:0];
         default: return;
      endcase
      scan_col = 0;
      scan_row = 0;
      nbhd     = '0;
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Valid is only lowered when a gap is taken, so back-to-back items keep it high.
   task automatic send_cell(logic alive);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cell_alive <= alive;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_next_states(alive);
      cells_sent++;
   endtask

   task automatic send_random(int unsigned count, int unsigned density);
      for (int unsigned i = 0; i < count; i++) send_cell($urandom_range(0, 99) < density);
   endtask

   task automatic send_pattern(logic [8:0] pattern);
      for (int i = 8; i >= 0; i--) send_cell(pattern[i]);
   endtask

   // Cells that cause no result may still be in flight, so settle before returning.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_states.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_index <= idx;
      csr_wdata <= data;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      apply_write(idx, data);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_geometry(int unsigned c, int unsigned r);
      write_reg(CSR_COLS, CSR_DATA_W'(c));
      write_reg(CSR_ROWS, CSR_DATA_W'(r));
      geometries++;
   endtask

   task automatic test_reset_geometry();
      send_random(40, 40);
   endtask

   task automatic test_directed_patterns();
      set_geometry(1, 1);
      send_cell(1'b1);
      send_cell(1'b0);
      // Zero sizes behave as a single cell.
      set_geometry(0, 0);
      send_cell(1'b1);
      set_geometry(3, 3);
      send_pattern(9'b010_010_010);
      // Writes to unused indexes must neither change the geometry nor restart the frame.
      for (int i = 0; i < 4; i++) send_cell(1'b1);
      write_reg(CSR_SPARE_2, 11'h7FF);
      write_reg(CSR_SPARE_3, 11'h000);
      for (int i = 0; i < 5; i++) send_cell(1'b1);
   endtask

   task automatic test_extreme_geometry();
      set_geometry(MAX_COLS, 1);
      send_random(32, 50);
      // Oversized values clamp to the maximum; the cols write also carries upper bits.
      set_geometry(11'h7FF, 11'h7FF);
      send_random(24, 50);
      set_geometry(33, MAX_ROWS);
      send_random(16, 50);
   endtask

   // The hold is under way before the first cell goes out, so the block fills up.
   task automatic test_output_hold();
      set_geometry(8, 4);
      quiet        = 1'b1;
      hold_request = 1'b1;
      wait (hold_active);
      send_random(32, 45);
      quiet = 1'b0;
   endtask

   task automatic test_midframe_restart();
      set_geometry(5, 4);
      send_random(13, 50);
      write_reg(CSR_ROWS, CSR_DATA_W'(4));
      send_random(20, 50);
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      set_geometry(6, 4);
      send_random(24, 40);
      set_geometry(1, 7);
      send_random(7, 60);
      quiet = 1'b0;
   endtask

   task automatic test_random_frames();
      int unsigned start, sel, size, frames, density;
      start = cells_sent;
      while (cells_sent - start < RANDOM_CELLS) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) set_geometry(MAX_COLS, 2);
         else if (sel == 1) set_geometry(1, $urandom_range(1, 12));
         else if (sel == 2) set_geometry($urandom_range(33, 63), 1);
         else set_geometry($urandom_range(1, 8), $urandom_range(1, 6));
         size   = grid_cols() * grid_rows();
         frames = $urandom_range(1, 2);
         for (int unsigned f = 0; f < frames; f++) begin
            density = $urandom_range(15, 65);
            // Now and then a frame is cut short; the next write restarts it.
            if ($urandom_range(0, 5) == 0) send_random($urandom_range(1, size), density);
            else send_random(size, density);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("life_generation_stencil test failed");
      $finish;
   end

   // Receiver side: random stall runs, quiet stretches, and one long hold when asked.
   initial begin
      int unsigned span;
      logic        stall_now;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall   <= 1'b1;
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active  = 1'b0;
            hold_request = 1'b0;
            holds_done++;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            stall_now = ($urandom_range(0, 99) < 35);
            if (!stall_now) span = $urandom_range(1, 20);
            else if ($urandom_range(0, 9) == 0) span = $urandom_range(10, 40);
            else span = $urandom_range(1, 3);
            rsp_stall <= stall_now;
            repeat (span) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_states.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: alive %0d col %0d row %0d last %0d",
                        rsp_next_alive, rsp_out_col, rsp_out_row, rsp_frame_last);
         end else begin
            want_state = pending_states.pop_front();
            if (rsp_next_alive !== want_state.alive || rsp_out_col !== want_state.col ||
                rsp_out_row !== want_state.row || rsp_frame_last !== want_state.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected alive %0d col %0d row %0d last %0d, got %0d %0d %0d %0d",
                           want_state.alive, want_state.col, want_state.row, want_state.last,
                           rsp_next_alive, rsp_out_col, rsp_out_row, rsp_frame_last);
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_geometry();
      test_directed_patterns();
      test_extreme_geometry();
      test_output_hold();
      test_midframe_restart();
      test_back_to_back();
      test_random_frames();
      wait_drained();
      $display("Sent %0d cells over %0d geometry settings and checked %0d next states.",
               cells_sent, geometries, results_seen);
      $display("Included zero and oversized sizes, mid-frame restarts and %0d long output hold(s).",
               holds_done);
      if (mismatches == 0) begin
         $display("life_generation_stencil test passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("life_generation_stencil test failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/lifegen_pkg.sv
rtl/lifegen_emit.sv
rtl/life_generation_stencil.sv
test/tb_top.sv
